/* sv/seg_pkg.sv */
// Shared constants and types for the signed Elias-gamma decoder.
package seg_pkg;

  localparam int MAX_CODE_BITS_DEF = 32;
  localparam int BITS_PER_BYTE     = 8;
  localparam int VALUE_W           = 32;
  localparam int BIT_CNT_W         = $clog2(BITS_PER_BYTE);

  // One result from the bit unit, before sign mapping is finished.
  typedef struct packed {
    logic               valid;
    logic               err;
    logic               neg;
    logic [VALUE_W-1:0] half;
  } seg_res_t;

  // Status from the result buffer back to the sequencer.
  typedef struct packed {
    logic pend_v;
    logic out_free;
  } seg_buf_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_FLUSH = 3'b100
  } seg_state_t;

endpackage

/* sv/seg_if.sv */
// Valid/ready channel interfaces for the decoder input and result items.
interface seg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface seg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] decoded_value;
  logic               code_error;
  logic               last_of_run;

  modport source (output valid, output decoded_value, output code_error,
                  output last_of_run, input ready);
  modport sink   (input valid, input decoded_value, input code_error,
                  input last_of_run, output ready);
endinterface

/* sv/seg_bit_unit.sv */
// Parser state and the Elias-gamma step, one bit per cycle while step_en is high.
module seg_bit_unit
  import seg_pkg::*;
#(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step_en,
  input  logic     bit_in,
  input  logic     restart,
  output seg_res_t res
);

  localparam int CNT_W = $clog2(MAX_CODE_BITS);
  localparam int ACC_W = MAX_CODE_BITS;
  localparam int EXT_W = (MAX_CODE_BITS > VALUE_W + 1) ? MAX_CODE_BITS : VALUE_W + 1;

  logic             reading_r, reading_nxt;
  logic [CNT_W-1:0] zero_run_r, zero_run_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [ACC_W-1:0] acc_shift;
  logic [EXT_W-1:0] c_ext;
  logic             done;

  assign acc_shift = {acc_r[ACC_W-2:0], bit_in};
  assign c_ext     = EXT_W'(acc_shift);

  always_comb begin
    reading_nxt  = reading_r;
    zero_run_nxt = zero_run_r;
    left_nxt     = left_r;
    acc_nxt      = acc_r;
    done         = 1'b0;
    res          = '0;
    if (!reading_r) begin
      if (!bit_in) begin
        if (zero_run_r == CNT_W'(MAX_CODE_BITS - 1)) begin
          // prefix too long: error item, zero bit dropped
          res.valid = 1'b1;
          res.err   = 1'b1;
          done      = 1'b1;
        end else begin
          zero_run_nxt = zero_run_r + CNT_W'(1);
        end
      end else if (zero_run_r == '0) begin
        // lone one bit is code 1, value 0
        res.valid = 1'b1;
        done      = 1'b1;
      end else begin
        reading_nxt = 1'b1;
        left_nxt    = zero_run_r;
        acc_nxt     = ACC_W'(1);
      end
    end else begin
      acc_nxt  = acc_shift;
      left_nxt = left_r - CNT_W'(1);
      if (left_r == CNT_W'(1)) begin
        res.valid = 1'b1;
        res.neg   = ~acc_shift[0];
        res.half  = c_ext[VALUE_W:1];
        done      = 1'b1;
      end
    end
    if (done || restart) begin
      reading_nxt  = 1'b0;
      zero_run_nxt = '0;
      left_nxt     = '0;
      acc_nxt      = ACC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reading_r  <= 1'b0;
      zero_run_r <= '0;
      left_r     <= '0;
      acc_r      <= ACC_W'(1);
    end else if (step_en) begin
      reading_r  <= reading_nxt;
      zero_run_r <= zero_run_nxt;
      left_r     <= left_nxt;
      acc_r      <= acc_nxt;
    end
  end

endmodule

/* sv/seg_out_buf.sv */
// Pending result register and output register with last-of-byte marking.
module seg_out_buf
  import seg_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_en,
  input  seg_res_t       push_res,
  input  logic           flush_en,
  output seg_buf_stat_t  stat,
  seg_out_if.source      out_ch
);

  logic               pend_v_r, pend_v_nxt;
  logic               pend_err_r;
  logic               pend_neg_r;
  logic [VALUE_W-1:0] pend_half_r;
  logic               out_v_r, out_v_nxt;
  logic [VALUE_W-1:0] out_val_r;
  logic               out_err_r;
  logic               out_last_r;
  logic               load;
  logic               load_last;
  logic [VALUE_W-1:0] mapped;

  assign stat.pend_v   = pend_v_r;
  assign stat.out_free = ~out_v_r | out_ch.ready;

  // held item leaves when a newer one arrives or the byte is done
  assign load_last = flush_en & pend_v_r;
  assign load      = (push_en & pend_v_r) | load_last;
  assign mapped    = pend_neg_r ? (VALUE_W'(0) - pend_half_r) : pend_half_r;

  always_comb begin
    pend_v_nxt = pend_v_r;
    if (push_en) begin
      pend_v_nxt = 1'b1;
    end else if (load_last) begin
      pend_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (load) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      pend_err_r  <= push_res.err;
      pend_neg_r  <= push_res.neg;
      pend_half_r <= push_res.half;
    end
    if (load) begin
      out_val_r  <= mapped;
      out_err_r  <= pend_err_r;
      out_last_r <= load_last;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.decoded_value = $signed(out_val_r);
  assign out_ch.code_error    = out_err_r;
  assign out_ch.last_of_run   = out_last_r;

endmodule

/* sv/signed_elias_gamma_decoder.sv */
// A byte is parsed one bit a cycle by the bit unit while the output does not stall.
// A result is held until the next result or byte end is seen; then it is moved out.
// Each byte takes its bit steps, then a flush state in which the next byte may be accepted;
// no new byte is taken during the bit steps, and output stalls hold the parser.
// Reset: synchronous active-low rst_n clears the parser, sequencer and result valids.
// Top level: byte sequencer around the bit unit and the result buffer.
module signed_elias_gamma_decoder
  import seg_pkg::*;
#(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  seg_in_if.sink    in_ch,
  seg_out_if.source out_ch
);

  seg_state_t             state_r, state_nxt;
  logic [7:0]             byte_r;
  logic                   eos_r;
  logic [BIT_CNT_W-1:0]   bit_cnt_r;
  logic                   accept;
  logic                   last_bit;
  logic                   stall;
  logic                   step_en;
  logic                   flush_done;
  logic                   flush_en;
  seg_res_t               res;
  seg_buf_stat_t          stat;

  assign last_bit   = (bit_cnt_r == BIT_CNT_W'(BITS_PER_BYTE - 1));
  // a second result while one is held needs room in the output register
  assign stall      = res.valid & stat.pend_v & ~stat.out_free;
  assign step_en    = (state_r == ST_RUN) & ~stall;
  assign flush_done = ~stat.pend_v | stat.out_free;
  assign flush_en   = (state_r == ST_FLUSH) & stat.pend_v & stat.out_free;
  assign in_ch.ready = (state_r == ST_IDLE) | ((state_r == ST_FLUSH) & flush_done);
  assign accept     = in_ch.valid & in_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (step_en && last_bit) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (accept) begin
          state_nxt = ST_RUN;
        end else if (flush_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      bit_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        bit_cnt_r <= '0;
      end else if (step_en) begin
        bit_cnt_r <= bit_cnt_r + BIT_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_ch.data_byte;
      eos_r  <= in_ch.end_of_stream;
    end else if (step_en) begin
      byte_r <= {byte_r[6:0], 1'b0};
    end
  end

  seg_bit_unit #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_bit (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .bit_in  (byte_r[7]),
    .restart (eos_r & last_bit),
    .res     (res)
  );

  seg_out_buf u_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_en  (step_en & res.valid),
    .push_res (res),
    .flush_en (flush_en),
    .stat     (stat),
    .out_ch   (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_RUN))
    else $error("accepted byte did not start parsing");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> !in_ch.ready)
    else $error("input ready while parsing a byte");

  a_flush_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FLUSH) && stat.pend_v && !stat.out_free) |=> (state_r == ST_FLUSH))
    else $error("left flush with a result still held");

  a_no_step_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res.valid && stat.pend_v) |-> stat.out_free)
    else $error("result pushed with no room to move the held item");
`endif

endmodule

/* test/testbench.sv */
// Self-checking testbench for the signed Elias-gamma decoder: code stream stimulus and scoreboard.
module testbench
  import seg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CODE_LIMIT    = MAX_CODE_BITS_DEF;
  localparam int PHASE_ITEMS   = 120;
  localparam int DRAIN_CYCLES  = 40;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } stream_byte_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               err;
    logic               last;
  } gamma_code_t;

  logic clk;
  logic rst_n;

  seg_in_if  in_ch();
  seg_out_if out_ch();

  signed_elias_gamma_decoder #(.MAX_CODE_BITS(CODE_LIMIT)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stream_byte_t pending_bytes[$];
  gamma_code_t  expected_codes[$];
  bit           stream_bits[$];
  stream_byte_t next_item;

  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  int queued_items      = 0;
  int accepted_items    = 0;
  int codes_checked     = 0;
  int prefix_errors     = 0;
  int busiest_byte      = 0;
  int mismatches        = 0;
  bit in_taken          = 1'b0;

  // Predictor state
  bit              in_payload;
  int unsigned     zeros_seen;
  int unsigned     payload_left;
  longint unsigned accum;

  initial begin
    clk   = 1'b0;
    rst_n = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("timeout: %0d of %0d items accepted, %0d results outstanding",
             accepted_items, queued_items, expected_codes.size());
    $display("status: fail");
    $finish;
  end

  task parser_clear();
    in_payload   = 1'b0;
    zeros_seen   = 0;
    payload_left = 0;
    accum        = 64'd1;
  endtask

  function automatic logic [31:0] zigzag_value(input longint unsigned c);
    logic [63:0] t;
    if (c == 64'd1)
      return 32'd0;
    if (c[0] == 1'b0) begin
      t = -(c >> 1);
      return t[31:0];
    end
    t = (c - 64'd1) >> 1;
    return t[31:0];
  endfunction

  task automatic predict_codes(input logic [7:0] data, input logic eos);
    gamma_code_t per_byte[$];
    gamma_code_t r;
    logic        b;
    for (int i = 7; i >= 0; i--) begin
      b = data[i];
      r.last = 1'b0;
      if (!in_payload) begin
        if (!b) begin
          if (zeros_seen >= CODE_LIMIT - 1) begin
            r.value = '0;
            r.err   = 1'b1;
            per_byte.push_back(r);
            prefix_errors++;
            parser_clear();
          end else begin
            zeros_seen++;
          end
        end else if (zeros_seen == 0) begin
          r.value = zigzag_value(64'd1);
          r.err   = 1'b0;
          per_byte.push_back(r);
          parser_clear();
        end else begin
          in_payload   = 1'b1;
          payload_left = zeros_seen;
          accum        = 64'd1;
        end
      end else begin
        accum = (accum << 1) | longint'(b);
        payload_left--;
        if (payload_left == 0) begin
          r.value = zigzag_value(accum);
          r.err   = 1'b0;
          per_byte.push_back(r);
          parser_clear();
        end
      end
    end
    if (eos)
      parser_clear();
    if (per_byte.size() > 0)
      per_byte[per_byte.size()-1].last = 1'b1;
    if (per_byte.size() > busiest_byte)
      busiest_byte = per_byte.size();
    foreach (per_byte[k])
      expected_codes.push_back(per_byte[k]);
  endtask

  task report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task push_byte(input logic [7:0] data, input logic eos);
    stream_byte_t s;
    s.data = data;
    s.eos  = eos;
    pending_bytes.push_back(s);
    queued_items++;
  endtask

  task append_code(input int v);
    longint unsigned c;
    int n;
    if (v == 0)
      c = 64'd1;
    else if (v > 0)
      c = longint'(v) * 2 + 1;
    else
      c = (-longint'(v)) * 2;
    n = 0;
    while ((c >> (n + 1)) != 0)
      n++;
    repeat (n) stream_bits.push_back(1'b0);
    for (int i = n; i >= 0; i--)
      stream_bits.push_back(c[i]);
  endtask

  // Pads with zeros to a whole byte; eos goes on the final byte.
  task flush_stream(input bit eos);
    logic [7:0] b;
    while (stream_bits.size() % 8 != 0)
      stream_bits.push_back(1'b0);
    while (stream_bits.size() > 0) begin
      for (int i = 7; i >= 0; i--)
        b[i] = stream_bits.pop_front();
      push_byte(b, eos && stream_bits.size() == 0);
    end
  endtask

  function automatic int random_value();
    int w;
    int v;
    w = ($urandom_range(1) == 0) ? $urandom_range(6) : $urandom_range(31);
    v = (w == 0) ? 0 : int'($urandom & ((32'd1 << w) - 1));
    return ($urandom_range(1) == 0) ? v : -v;
  endfunction

  task load_directed();
    push_byte(8'hFF, 1'b0);              // eight zero codes from one byte
    push_byte(8'h00, 1'b1);              // bare padding dropped
    push_byte(8'h01, 1'b1);              // partial code dropped at end of stream
    push_byte(8'hFF, 1'b0);
    repeat (4) push_byte(8'h00, 1'b0);   // prefix too long on the last zero
    push_byte(8'h00, 1'b1);
    append_code(1);
    append_code(-1);
    append_code(2147483647);
    append_code(-2147483647);
    append_code(0);
    flush_stream(1'b1);
    append_code(-1073741824);
    append_code(12345);
    flush_stream(1'b1);
  endtask

  task load_random(input int target);
    int start;
    int kind;
    int drop;
    start = queued_items;
    while (queued_items - start < target) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        repeat ($urandom_range(1, 6)) append_code(random_value());
        flush_stream(1'b1);
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 3))
          push_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
        push_byte(8'($urandom_range(255)), 1'b1);
      end else if (kind < 95) begin
        repeat ($urandom_range(1, 4)) append_code(random_value());
        drop = $urandom_range(1, (stream_bits.size() > 20) ? 20 : stream_bits.size() - 1);
        repeat (drop) void'(stream_bits.pop_back());
        flush_stream(1'b1);
      end else begin
        repeat ($urandom_range(4, 5)) push_byte(8'h00, 1'b0);
        push_byte(8'($urandom_range(255)), 1'b1);
      end
    end
  endtask

  initial begin
    parser_clear();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct   = (phase == 0) ? 7 : (phase == 1) ? 85 : 0;
      receiver_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 7 : 0;
      if (phase == 0)
        load_directed();
      load_random(PHASE_ITEMS);
      // sender holds off until every result so far has been taken
      wait (accepted_items == queued_items && expected_codes.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end
    if (expected_codes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_codes.size()));
    $display("summary: %0d bytes decoded into %0d results, %0d prefix errors, up to %0d per byte",
             accepted_items, codes_checked, prefix_errors, busiest_byte);
    $display("summary: %0d mismatches over three idling phases", mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid         <= 1'b0;
      in_ch.data_byte     <= 8'h00;
      in_ch.end_of_stream <= 1'b0;
      out_ch.ready        <= 1'b0;
    end else begin
      if (!in_ch.valid || in_taken) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_item = pending_bytes.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.data_byte     <= next_item.data;
          in_ch.end_of_stream <= next_item.eos;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    gamma_code_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        predict_codes(in_ch.data_byte, in_ch.end_of_stream);
        accepted_items++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_codes.size() == 0) begin
          report_mismatch($sformatf("unexpected item value=%0d err=%0b last=%0b",
                                    out_ch.decoded_value, out_ch.code_error,
                                    out_ch.last_of_run));
        end else begin
          want = expected_codes.pop_front();
          codes_checked++;
          if (out_ch.decoded_value !== want.value || out_ch.code_error !== want.err ||
              out_ch.last_of_run !== want.last)
            report_mismatch($sformatf(
              "result %0d: expected value=%0d err=%0b last=%0b, got value=%0d err=%0b last=%0b",
              codes_checked, want.value, want.err, want.last,
              out_ch.decoded_value, out_ch.code_error, out_ch.last_of_run));
        end
      end
    end
  end

endmodule
